// ===== hw/rtl/ultrasonic_distance_frame_parser_core_defines.svh =====
// Assertion macros shared by the frame parser RTL.
// Each expects signals named clock and reset in the module that uses it.
`ifndef ULTRASONIC_DISTANCE_FRAME_PARSER_CORE_DEFINES_SVH
`define ULTRASONIC_DISTANCE_FRAME_PARSER_CORE_DEFINES_SVH

// Checked outside reset only.
`define UDFP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define UDFP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/udfp_pkg.sv =====
// Types and constants of the ultrasonic distance frame parser.
// Used by the interfaces and by every module of the block.
package udfp_pkg;

   localparam logic [7:0]  TRIG_SUMMED    = 8'h55;
   localparam logic [7:0]  TRIG_RAW       = 8'hA0;
   localparam logic [7:0]  FRAME_HEAD     = 8'hFF;
   localparam logic [15:0] MIN_DIST_RESET = 16'd250;

   localparam logic [1:0] MODEL_SUM3 = 2'd0;
   localparam logic [1:0] MODEL_SUM2 = 2'd1;
   localparam logic [1:0] MODEL_RAW  = 2'd2;

   localparam logic CMD_RX_BYTE = 1'b0;
   localparam logic CMD_MEASURE = 1'b1;

   localparam logic CSR_SENSOR_MODEL = 1'b0;
   localparam logic CSR_MIN_DIST     = 1'b1;

   localparam int FRAME_DEPTH = 3;

   typedef enum logic [1:0] {
      KIND_TRIGGER   = 2'd0,
      KIND_VALID     = 2'd1,
      KIND_CHK_FAIL  = 2'd2,
      KIND_TOO_SMALL = 2'd3
   } result_kind_type;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      result_kind_type result_kind;
      logic [7:0]      tx_byte;
      logic [23:0]     distance_raw;
      logic [7:0]      received_checksum;
   } result_type;

   typedef struct packed {
      logic [1:0]  sensor_model;
      logic [15:0] min_valid_distance;
   } cfg_type;

endpackage

// ===== hw/rtl/udfp_if.sv =====
// Channel interfaces of the frame parser: request, response and register write.
// Depends on udfp_pkg for the result kind type.
interface udfp_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;
   modport source (output valid, command, rx_byte, input ready);
   modport sink (input valid, command, rx_byte, output ready);
endinterface

interface udfp_rsp_if;
   logic                     valid;
   logic                     ready;
   udfp_pkg::result_kind_type result_kind;
   logic [7:0]               tx_byte;
   logic [23:0]              distance_raw;
   logic [7:0]               received_checksum;
   modport source (output valid, result_kind, tx_byte, distance_raw, received_checksum,
                   input ready);
   modport sink (input valid, result_kind, tx_byte, distance_raw, received_checksum,
                 output ready);
endinterface

interface udfp_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/udfp_csr_bank.sv =====
// Configuration registers: sensor model and minimum valid distance.
// Depends on udfp_pkg and udfp_csr_if.
module udfp_csr_bank (
   input  logic              clock,
   input  logic              reset,
   udfp_csr_if.sink          csr,
   output udfp_pkg::cfg_type cfg
);

   udfp_pkg::cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_model       <= udfp_pkg::MODEL_SUM3;
         cfg_ff.min_valid_distance <= udfp_pkg::MIN_DIST_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            udfp_pkg::CSR_SENSOR_MODEL: cfg_ff.sensor_model       <= csr.data[1:0];
            udfp_pkg::CSR_MIN_DIST:     cfg_ff.min_valid_distance <= csr.data;
         endcase
      end
   end

endmodule

// ===== hw/rtl/udfp_frame_engine.sv =====
// Input register, frame store and the per-byte framing and checksum logic.
// Depends on udfp_pkg, udfp_req_if and the assertion macro header.
`include "ultrasonic_distance_frame_parser_core_defines.svh"

module udfp_frame_engine (
   input  logic                 clock,
   input  logic                 reset,
   udfp_req_if.sink             req,
   input  udfp_pkg::cfg_type    cfg,
   input  logic                 res_ready,
   output logic                 res_valid,
   output udfp_pkg::result_type res
);

   logic               s1_valid_ff, s1_valid_in;
   udfp_pkg::item_type item_ff;
   logic [7:0]         frame_ff [udfp_pkg::FRAME_DEPTH];
   logic [1:0]         count_ff, count_in;
   logic               store_en;
   logic               emit;
   logic               fire;
   logic [7:0]         sum3;
   logic [7:0]         sum2;
   logic [15:0]        dist_mm;
   logic [7:0]         chk_calc;

   // The held item is worked on in the cycle the result side can take it.
   assign fire        = s1_valid_ff && res_ready;
   assign req.ready   = !s1_valid_ff || res_ready;
   assign s1_valid_in = req.valid ? 1'b1 : (s1_valid_ff && !res_ready);

   assign sum3     = frame_ff[0] + frame_ff[1] + frame_ff[2];
   assign sum2     = frame_ff[1] + frame_ff[2];
   assign dist_mm  = {frame_ff[1], frame_ff[2]};
   assign chk_calc = (cfg.sensor_model == udfp_pkg::MODEL_SUM3) ? sum3 : sum2;

   always_comb begin
      count_in = count_ff;
      store_en = 1'b0;
      emit     = 1'b0;
      res      = '0;
      if (fire) begin
         unique case (cfg.sensor_model)
            udfp_pkg::MODEL_RAW: begin
               if (item_ff.command == udfp_pkg::CMD_MEASURE) begin
                  count_in    = '0;
                  emit        = 1'b1;
                  res.tx_byte = udfp_pkg::TRIG_RAW;
               end else if (count_ff < 2'd2) begin
                  store_en = 1'b1;
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in         = '0;
                  emit             = 1'b1;
                  res.result_kind  = udfp_pkg::KIND_VALID;
                  res.distance_raw = {frame_ff[0], frame_ff[1], item_ff.rx_byte};
               end
            end
            udfp_pkg::MODEL_SUM3, udfp_pkg::MODEL_SUM2: begin
               if (item_ff.command == udfp_pkg::CMD_MEASURE) begin
                  emit        = 1'b1;
                  res.tx_byte = udfp_pkg::TRIG_SUMMED;
               end else if (count_ff == 2'd0 && item_ff.rx_byte != udfp_pkg::FRAME_HEAD) begin
                  // Hunting for the header: the byte is dropped.
                  count_in = count_ff;
               end else if (count_ff < 2'd3) begin
                  store_en = 1'b1;
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in              = '0;
                  emit                  = 1'b1;
                  res.received_checksum = item_ff.rx_byte;
                  if (chk_calc != item_ff.rx_byte) begin
                     res.result_kind = udfp_pkg::KIND_CHK_FAIL;
                  end else begin
                     res.distance_raw = {8'd0, dist_mm};
                     res.result_kind  = (dist_mm > cfg.min_valid_distance) ?
                                        udfp_pkg::KIND_VALID : udfp_pkg::KIND_TOO_SMALL;
                  end
               end
            end
            default: begin
               // The unused model code swallows every request.
               emit = 1'b0;
            end
         endcase
      end
   end

   assign res_valid = fire && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff    <= '0;
         frame_ff[0] <= '0;
         frame_ff[1] <= '0;
         frame_ff[2] <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         count_ff    <= count_in;
         if (store_en) begin
            frame_ff[count_ff] <= item_ff.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.command <= req.command;
         item_ff.rx_byte <= req.rx_byte;
      end
   end

   `UDFP_ASSERT(a_held_item_stable, s1_valid_ff && !res_ready |=> s1_valid_ff && $stable(item_ff), "held request changed while stalled")
   `UDFP_ASSERT(a_trigger_byte, res_valid && res.result_kind == udfp_pkg::KIND_TRIGGER |-> res.tx_byte == udfp_pkg::TRIG_SUMMED || res.tx_byte == udfp_pkg::TRIG_RAW, "bad trigger byte")
   `UDFP_ASSERT(a_frame_done_clears, res_valid && res.result_kind != udfp_pkg::KIND_TRIGGER |=> count_ff == 2'd0, "frame store not emptied after a frame result")

endmodule

// ===== hw/rtl/udfp_result_stage.sv =====
// Output register that holds a finished result until the response side takes it.
// Depends on udfp_pkg, udfp_rsp_if and the assertion macro header.
`include "ultrasonic_distance_frame_parser_core_defines.svh"

module udfp_result_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  udfp_pkg::result_type res,
   output logic                 res_ready,
   udfp_rsp_if.source           rsp
);

   logic                 valid_ff, valid_in;
   udfp_pkg::result_type data_ff;

   assign res_ready = !valid_ff || rsp.ready;
   assign valid_in  = res_ready ? res_valid : valid_ff;

   assign rsp.valid             = valid_ff;
   assign rsp.result_kind       = data_ff.result_kind;
   assign rsp.tx_byte           = data_ff.tx_byte;
   assign rsp.distance_raw      = data_ff.distance_raw;
   assign rsp.received_checksum = data_ff.received_checksum;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         data_ff <= res;
      end
   end

   `UDFP_ASSERT_ALWAYS(a_empty_after_reset, reset |=> !valid_ff, "output register not empty after reset")
   `UDFP_ASSERT(a_result_loaded, res_valid && res_ready |=> valid_ff, "accepted result was lost")

endmodule

// ===== hw/rtl/ultrasonic_distance_frame_parser_core.sv =====
// Top level of the ultrasonic distance frame parser.
// Depends on udfp_pkg, the channel interfaces and the udfp_* modules.
//
//   Channel    Direction  Carries
//   req_chan   in         command, rx_byte
//   rsp_chan   out        result_kind, tx_byte, distance_raw, received_checksum
//   csr_chan   in         index (0 sensor model, 1 minimum distance), data
//
// A request is registered in the input register, worked on there while the result
// side can take it, and its result, if any, is then registered in the output register;
// one request per cycle is taken while the response side does not stall.
// Reset is synchronous and active high; it empties the frame store and both stages.
// A stalled response holds the output register, and the input register then fills.
module ultrasonic_distance_frame_parser_core (
   input  logic       clock,
   input  logic       reset,
   udfp_req_if.sink   req_chan,
   udfp_rsp_if.source rsp_chan,
   udfp_csr_if.sink   csr_chan
);

   udfp_pkg::cfg_type    cfg;
   udfp_pkg::result_type res;
   logic                 res_valid;
   logic                 res_ready;

   udfp_csr_bank u_csr_bank (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   udfp_frame_engine u_frame_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg),
      .res_ready (res_ready),
      .res_valid (res_valid),
      .res       (res)
   );

   udfp_result_stage u_result_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .rsp       (rsp_chan)
   );

endmodule
